>>> sv/srv_pkg.sv
// Shared types, constants and codes of the Schroeder reverb block.
package srv_pkg;

   localparam int LEN_W      = 12;
   localparam int AP_LEN_W   = 9;
   localparam int GAIN_W     = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int WORD_W     = 24;
   localparam int SUM_W      = 26;
   localparam int A_W        = 25;
   localparam int B_W        = 18;
   localparam int ACC_W      = 48;

   localparam logic [GAIN_W-1:0] UNITY   = 17'd65536;
   localparam logic [GAIN_W-1:0] FB_BASE = 17'd32768;
   localparam logic [GAIN_W-1:0] FB_SPAN = 17'd26214;

   localparam logic [3:0][LEN_W-1:0]    RST_COMB_LEN =
      {12'd1927, 12'd1812, 12'd1636, 12'd1309};
   localparam logic [1:0][AP_LEN_W-1:0] RST_AP_LEN = {9'd74, 9'd220};
   localparam logic [GAIN_W-1:0]        RST_ROOM   = 17'd32768;
   localparam logic [GAIN_W-1:0]        RST_WET    = 17'd19661;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMB_LEN_0,
      CSR_COMB_LEN_1,
      CSR_COMB_LEN_2,
      CSR_COMB_LEN_3,
      CSR_ALLPASS_LEN_0,
      CSR_ALLPASS_LEN_1,
      CSR_ROOM_SIZE,
      CSR_WET_MIX
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_GAIN,
      S_COMB,
      S_AP_A,
      S_AP_B,
      S_MIX_W,
      S_MIX_L,
      S_MIX_R
   } state_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_1,
      SH_16
   } shift_type;

   typedef struct packed {
      logic      sub;
      shift_type shift;
   } alu_op_type;

   // clamped, ready-to-use configuration
   typedef struct packed {
      logic [3:0][LEN_W-1:0]    comb_len;
      logic [1:0][AP_LEN_W-1:0] ap_len;
      logic [GAIN_W-1:0]        room;
      logic [GAIN_W-1:0]        wet;
      logic [GAIN_W-1:0]        dry;
   } cfg_type;

endpackage

>>> sv/srv_if.sv
// Valid/ready channel interfaces for the reverb's sample frames.
interface srv_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, left_in, right_in, input ready);
   modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface srv_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink   (input valid, left_out, right_out, output ready);
endinterface

>>> sv/schroeder_reverb.sv
// Top level of the Schroeder reverb: sequencer, delay-line state and result register.
//
// Usage:
//  - req_ch carries one stereo frame (left_in, right_in) per item, rsp_ch one
//    mixed frame (left_out, right_out). Both are valid/ready; an item moves
//    at a clock edge with valid and ready high.
//  - csr_we/csr_index/csr_wdata write the length, room size and wet mix
//    registers; write them only while no frame is in flight.
//  - Each frame runs through the gain step, four comb updates, two times two
//    all-pass steps and three mix products in turn on the single shared
//    multiply-add unit before it reaches the result register; req_ch is ready
//    again in the cycle after that, and no new frame is taken before then.
//  - Reset clears the line positions, then a clearing pass zeroes the comb
//    and all-pass RAMs, one word a cycle. req_ch stays not ready meanwhile;
//    configuration writes are taken throughout.
//  - The result sits in an output register; a stalled receiver holds it
//    there while the next frame is accepted and processed. That frame waits
//    in its last mix step until the register is free.
module schroeder_reverb import srv_pkg::*; #(
   parameter int COMB_DEPTH    = 2048,
   parameter int ALLPASS_DEPTH = 256,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   srv_req_if.sink               req_ch,
   srv_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CD_W  = $clog2(COMB_DEPTH);
   localparam int CA_W  = $clog2(4 * COMB_DEPTH);
   localparam int AD_W  = $clog2(ALLPASS_DEPTH);
   localparam int AA_W  = $clog2(2 * ALLPASS_DEPTH);
   localparam int CLR_N = (4 * COMB_DEPTH > 2 * ALLPASS_DEPTH) ?
                          4 * COMB_DEPTH : 2 * ALLPASS_DEPTH;
   localparam int CLR_W = $clog2(CLR_N);
   localparam int CMP_W = 17;
   localparam logic signed [ACC_W-1:0] SMAX =
      (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

   // output saturation of the Q16-scaled mix
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_W-1:0] s);
      logic signed [ACC_W-1:0] v;
      v = s >>> 16;
      if (v > SMAX) begin
         return SAMPLE_BITS'(SMAX);
      end else if (v < SMIN) begin
         return SAMPLE_BITS'(SMIN);
      end
      return SAMPLE_BITS'(v);
   endfunction

   cfg_type cfg;

   srv_csr #(
      .COMB_DEPTH    (COMB_DEPTH),
      .ALLPASS_DEPTH (ALLPASS_DEPTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer state
   state_type        state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [1:0]       line_ff, line_in;
   logic             ap_line_ff, ap_line_in;

   // line positions
   logic [CD_W-1:0] comb_idx_ff [4];
   logic [CD_W-1:0] comb_idx_in [4];
   logic [AD_W-1:0] ap_idx_ff   [2];
   logic [AD_W-1:0] ap_idx_in   [2];

   // per-frame working registers
   logic signed [SAMPLE_BITS-1:0] dry_l_ff, dry_l_in;
   logic signed [SAMPLE_BITS-1:0] dry_r_ff, dry_r_in;
   logic signed [SAMPLE_BITS-1:0] mono_ff, mono_in;
   logic [GAIN_W-1:0]             g_ff, g_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [WORD_W-1:0]      x_ff, x_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [SAMPLE_BITS-1:0] left_tmp_ff, left_tmp_in;

   // access captured at read time, used at write time
   logic [CD_W-1:0]     cpos_ff, cpos_in;
   logic [LEN_W-1:0]    clen_ff, clen_in;
   logic [CA_W-1:0]     caddr_ff, caddr_in;
   logic [AD_W-1:0]     apos_ff, apos_in;
   logic [AP_LEN_W-1:0] alen_ff, alen_in;
   logic [AA_W-1:0]     aaddr_ff, aaddr_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;

   // RAM ports
   logic                     comb_we, comb_re;
   logic [CA_W-1:0]          comb_waddr, comb_raddr;
   logic signed [WORD_W-1:0] comb_wdata, comb_rdata;
   logic                     ap_we, ap_re;
   logic [AA_W-1:0]          ap_waddr, ap_raddr;
   logic signed [WORD_W-1:0] ap_wdata, ap_rdata;

   // shared unit
   alu_op_type               alu_op;
   logic signed [A_W-1:0]    alu_a;
   logic signed [B_W-1:0]    alu_b;
   logic signed [ACC_W-1:0]  alu_c;
   logic signed [ACC_W-1:0]  alu_sum;
   logic signed [WORD_W-1:0] alu_word;

   // read-side address generation
   logic [1:0]          c_rd_line;
   logic [LEN_W-1:0]    c_rd_len;
   logic [CD_W-1:0]     c_rd_eff;
   logic [CA_W-1:0]     c_rd_addr;
   logic [CD_W-1:0]     c_nxt;
   logic                a_rd_line;
   logic [AP_LEN_W-1:0] a_rd_len;
   logic [AD_W-1:0]     a_rd_eff;
   logic [AA_W-1:0]     a_rd_addr;
   logic [AD_W-1:0]     a_nxt;
   logic signed [WORD_W-1:0] x_cur;

   srv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (4 * COMB_DEPTH)
   ) u_comb_ram (
      .clock (clock),
      .we    (comb_we),
      .waddr (comb_waddr),
      .wdata (comb_wdata),
      .re    (comb_re),
      .raddr (comb_raddr),
      .rdata (comb_rdata)
   );

   srv_ram #(
      .WIDTH (WORD_W),
      .DEPTH (2 * ALLPASS_DEPTH)
   ) u_ap_ram (
      .clock (clock),
      .we    (ap_we),
      .waddr (ap_waddr),
      .wdata (ap_wdata),
      .re    (ap_re),
      .raddr (ap_raddr),
      .rdata (ap_rdata)
   );

   srv_alu u_alu (
      .op   (alu_op),
      .a    (alu_a),
      .b    (alu_b),
      .c    (alu_c),
      .sum  (alu_sum),
      .word (alu_word)
   );

   // Next line to read: comb 0 during the gain step, then the one after the
   // line being written. A position left past a shortened length restarts at 0.
   always_comb begin
      c_rd_line = (state_ff == S_GAIN) ? 2'd0 : 2'(line_ff + 2'd1);
      c_rd_len  = cfg.comb_len[c_rd_line];
      c_rd_eff  = (CMP_W'(comb_idx_ff[c_rd_line]) >= CMP_W'(c_rd_len)) ?
                  '0 : comb_idx_ff[c_rd_line];
      c_rd_addr = CA_W'(c_rd_line) * CA_W'(COMB_DEPTH) + CA_W'(c_rd_eff);
      c_nxt     = (CMP_W'(cpos_ff) + CMP_W'(1) >= CMP_W'(clen_ff)) ?
                  '0 : CD_W'(cpos_ff + 1'b1);

      a_rd_line = (state_ff == S_COMB) ? 1'b0 : 1'b1;
      a_rd_len  = cfg.ap_len[a_rd_line];
      a_rd_eff  = (CMP_W'(ap_idx_ff[a_rd_line]) >= CMP_W'(a_rd_len)) ?
                  '0 : ap_idx_ff[a_rd_line];
      a_rd_addr = AA_W'(a_rd_line) * AA_W'(ALLPASS_DEPTH) + AA_W'(a_rd_eff);
      a_nxt     = (CMP_W'(apos_ff) + CMP_W'(1) >= CMP_W'(alen_ff)) ?
                  '0 : AD_W'(apos_ff + 1'b1);

      // comb sum /4 always fits a word, no saturation needed
      x_cur = ap_line_ff ? x_ff : sum_ff[SUM_W-1:2];
   end

   // sequencer: next state, unit operands, RAM strobes, register updates
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      line_in      = line_ff;
      ap_line_in   = ap_line_ff;
      comb_idx_in  = comb_idx_ff;
      ap_idx_in    = ap_idx_ff;
      dry_l_in     = dry_l_ff;
      dry_r_in     = dry_r_ff;
      mono_in      = mono_ff;
      g_in         = g_ff;
      sum_in       = sum_ff;
      x_in         = x_ff;
      acc_in       = acc_ff;
      left_tmp_in  = left_tmp_ff;
      cpos_in      = cpos_ff;
      clen_in      = clen_ff;
      caddr_in     = caddr_ff;
      apos_in      = apos_ff;
      alen_in      = alen_ff;
      aaddr_in     = aaddr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;

      comb_we    = 1'b0;
      comb_waddr = caddr_ff;
      comb_wdata = alu_word;
      comb_re    = 1'b0;
      comb_raddr = c_rd_addr;
      ap_we      = 1'b0;
      ap_waddr   = aaddr_ff;
      ap_wdata   = alu_word;
      ap_re      = 1'b0;
      ap_raddr   = a_rd_addr;

      alu_op.sub   = 1'b0;
      alu_op.shift = SH_0;
      alu_a        = '0;
      alu_b        = '0;
      alu_c        = '0;

      req_ch.ready = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            comb_we    = 32'(clr_ff) < 4 * COMB_DEPTH;
            comb_waddr = CA_W'(clr_ff);
            comb_wdata = '0;
            ap_we      = 32'(clr_ff) < 2 * ALLPASS_DEPTH;
            ap_waddr   = AA_W'(clr_ff);
            ap_wdata   = '0;
            clr_in     = CLR_W'(clr_ff + 1'b1);
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               dry_l_in = req_ch.left_in;
               dry_r_in = req_ch.right_in;
               mono_in  = SAMPLE_BITS'(({req_ch.left_in[SAMPLE_BITS-1], req_ch.left_in} +
                                        {req_ch.right_in[SAMPLE_BITS-1], req_ch.right_in})
                                       >> 1);
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            // feedback gain = 0.5 + 0.4 * room
            alu_op.shift = SH_16;
            alu_a        = A_W'($signed({1'b0, cfg.room}));
            alu_b        = B_W'($signed({1'b0, FB_SPAN}));
            alu_c        = ACC_W'($signed({1'b0, FB_BASE}));
            g_in         = alu_sum[GAIN_W-1:0];
            sum_in       = '0;
            line_in      = 2'd0;
            comb_re      = 1'b1;
            cpos_in      = c_rd_eff;
            clen_in      = c_rd_len;
            caddr_in     = c_rd_addr;
            state_in     = S_COMB;
         end
         S_COMB: begin
            // word = sat(mono + y*g), sum += y
            alu_op.shift         = SH_16;
            alu_a                = A_W'(comb_rdata);
            alu_b                = B_W'($signed({1'b0, g_ff}));
            alu_c                = ACC_W'(mono_ff);
            comb_we              = 1'b1;
            sum_in               = sum_ff + SUM_W'(comb_rdata);
            comb_idx_in[line_ff] = c_nxt;
            if (line_ff != 2'd3) begin
               comb_re  = 1'b1;
               cpos_in  = c_rd_eff;
               clen_in  = c_rd_len;
               caddr_in = c_rd_addr;
               line_in  = 2'(line_ff + 2'd1);
            end else begin
               ap_re      = 1'b1;
               apos_in    = a_rd_eff;
               alen_in    = a_rd_len;
               aaddr_in   = a_rd_addr;
               ap_line_in = 1'b0;
               state_in   = S_AP_A;
            end
         end
         S_AP_A: begin
            // word = sat(x + b/2)
            alu_op.shift          = SH_1;
            alu_a                 = A_W'(ap_rdata);
            alu_b                 = B_W'(1);
            alu_c                 = ACC_W'(x_cur);
            ap_we                 = 1'b1;
            x_in                  = x_cur;
            ap_idx_in[ap_line_ff] = a_nxt;
            state_in              = S_AP_B;
         end
         S_AP_B: begin
            // x = sat(b - x/2); read data held since no read was issued
            alu_op.sub   = 1'b1;
            alu_op.shift = SH_1;
            alu_a        = A_W'(x_ff);
            alu_b        = B_W'(1);
            alu_c        = ACC_W'(ap_rdata);
            x_in         = alu_word;
            if (!ap_line_ff) begin
               ap_re      = 1'b1;
               apos_in    = a_rd_eff;
               alen_in    = a_rd_len;
               aaddr_in   = a_rd_addr;
               ap_line_in = 1'b1;
               state_in   = S_AP_A;
            end else begin
               state_in = S_MIX_W;
            end
         end
         S_MIX_W: begin
            alu_a    = A_W'(x_ff);
            alu_b    = B_W'($signed({1'b0, cfg.wet}));
            acc_in   = alu_sum;
            state_in = S_MIX_L;
         end
         S_MIX_L: begin
            alu_a       = A_W'(dry_l_ff);
            alu_b       = B_W'($signed({1'b0, cfg.dry}));
            alu_c       = acc_ff;
            left_tmp_in = sat_sample(alu_sum);
            state_in    = S_MIX_R;
         end
         S_MIX_R: begin
            alu_a = A_W'(dry_r_ff);
            alu_b = B_W'($signed({1'b0, cfg.dry}));
            alu_c = acc_ff;
            // wait here while the previous result is still held
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = left_tmp_ff;
               rsp_right_in = sat_sample(alu_sum);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         line_ff      <= '0;
         ap_line_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            comb_idx_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            ap_idx_ff[i] <= '0;
         end
      end else begin
         clr_ff       <= clr_in;
         line_ff      <= line_in;
         ap_line_ff   <= ap_line_in;
         rsp_valid_ff <= rsp_valid_in;
         comb_idx_ff  <= comb_idx_in;
         ap_idx_ff    <= ap_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      dry_l_ff     <= dry_l_in;
      dry_r_ff     <= dry_r_in;
      mono_ff      <= mono_in;
      g_ff         <= g_in;
      sum_ff       <= sum_in;
      x_ff         <= x_in;
      acc_ff       <= acc_in;
      left_tmp_ff  <= left_tmp_in;
      cpos_ff      <= cpos_in;
      clen_ff      <= clen_in;
      caddr_ff     <= caddr_in;
      apos_ff      <= apos_in;
      alen_ff      <= alen_in;
      aaddr_ff     <= aaddr_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.left_out  = rsp_left_ff;
   assign rsp_ch.right_out = rsp_right_ff;

   // read and write of a delay RAM never hit the same word in one cycle
   a_comb_no_collide: assert property (@(posedge clock) disable iff (reset)
      comb_we && comb_re |-> comb_waddr != comb_raddr)
      else $error("comb RAM read and write at the same address");

   a_ap_no_collide: assert property (@(posedge clock) disable iff (reset)
      ap_we && ap_re |-> ap_waddr != ap_raddr)
      else $error("all-pass RAM read and write at the same address");

   // a result only appears out of the last mix step
   a_rsp_from_mix: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_MIX_R))
      else $error("result loaded outside the final mix step");

   // all-pass steps are entered only from the last comb or a finished pair
   a_ap_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_AP_A |-> $past(state_ff == S_COMB || state_ff == S_AP_B))
      else $error("all-pass step entered out of sequence");

endmodule

>>> sv/srv_ram.sv
// Generic simple dual-port RAM with registered read.
module srv_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/srv_alu.sv
// Shared multiply, shift and add/subtract unit with 24-bit saturation.
module srv_alu import srv_pkg::*; (
   input  alu_op_type               op,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   input  logic signed [ACC_W-1:0]  c,
   output logic signed [ACC_W-1:0]  sum,
   output logic signed [WORD_W-1:0] word
);

   localparam logic signed [ACC_W-1:0] WMAX = (ACC_W'(1) <<< (WORD_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] WMIN = -WMAX - ACC_W'(1);

   logic signed [A_W+B_W-1:0] prod;
   logic signed [ACC_W-1:0]   pext;
   logic signed [ACC_W-1:0]   shifted;

   always_comb begin
      prod = a * b;
      pext = ACC_W'(prod);
      unique case (op.shift)
         SH_0:    shifted = pext;
         SH_1:    shifted = pext >>> 1;
         SH_16:   shifted = pext >>> 16;
         default: shifted = pext;
      endcase
      sum = op.sub ? (c - shifted) : (c + shifted);
      if (sum > WMAX) begin
         word = WORD_W'(WMAX);
      end else if (sum < WMIN) begin
         word = WORD_W'(WMIN);
      end else begin
         word = WORD_W'(sum);
      end
   end

endmodule

>>> sv/srv_csr.sv
// Configuration registers with range clamping for lengths and gains.
module srv_csr import srv_pkg::*; #(
   parameter int COMB_DEPTH    = 2048,
   parameter int ALLPASS_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [LEN_W-1:0]    comb_len_ff [4];
   logic [AP_LEN_W-1:0] ap_len_ff   [2];
   logic [GAIN_W-1:0]   room_ff;
   logic [GAIN_W-1:0]   wet_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            comb_len_ff[i] <= RST_COMB_LEN[i];
         end
         for (int i = 0; i < 2; i++) begin
            ap_len_ff[i] <= RST_AP_LEN[i];
         end
         room_ff <= RST_ROOM;
         wet_ff  <= RST_WET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_COMB_LEN_0:    comb_len_ff[0] <= csr_wdata[LEN_W-1:0];
            CSR_COMB_LEN_1:    comb_len_ff[1] <= csr_wdata[LEN_W-1:0];
            CSR_COMB_LEN_2:    comb_len_ff[2] <= csr_wdata[LEN_W-1:0];
            CSR_COMB_LEN_3:    comb_len_ff[3] <= csr_wdata[LEN_W-1:0];
            CSR_ALLPASS_LEN_0: ap_len_ff[0]   <= csr_wdata[AP_LEN_W-1:0];
            CSR_ALLPASS_LEN_1: ap_len_ff[1]   <= csr_wdata[AP_LEN_W-1:0];
            CSR_ROOM_SIZE:     room_ff        <= csr_wdata[GAIN_W-1:0];
            CSR_WET_MIX:       wet_ff         <= csr_wdata[GAIN_W-1:0];
         endcase
      end
   end

   // lengths to 1..depth, gains to at most unity
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (comb_len_ff[i] == '0) begin
            cfg.comb_len[i] = LEN_W'(1);
         end else if (32'(comb_len_ff[i]) > COMB_DEPTH) begin
            cfg.comb_len[i] = LEN_W'(COMB_DEPTH);
         end else begin
            cfg.comb_len[i] = comb_len_ff[i];
         end
      end
      for (int i = 0; i < 2; i++) begin
         if (ap_len_ff[i] == '0) begin
            cfg.ap_len[i] = AP_LEN_W'(1);
         end else if (32'(ap_len_ff[i]) > ALLPASS_DEPTH) begin
            cfg.ap_len[i] = AP_LEN_W'(ALLPASS_DEPTH);
         end else begin
            cfg.ap_len[i] = ap_len_ff[i];
         end
      end
      cfg.room = (room_ff > UNITY) ? UNITY : room_ff;
      cfg.wet  = (wet_ff > UNITY) ? UNITY : wet_ff;
      cfg.dry  = UNITY - cfg.wet;
   end

endmodule
